>>> rtl/core/mcp_pkg.sv
// ----------------------------------------------------------------------------
// mcp_pkg: shared types and constants for the marker pose core
// Beat layouts, register indexes, datapath widths and the arctangent table.
// ----------------------------------------------------------------------------
package mcp_pkg;

  typedef struct packed {
    logic [15:0] marker_id;
    logic [15:0] corner0_x;
    logic [15:0] corner0_y;
    logic [15:0] corner1_x;
    logic [15:0] corner1_y;
    logic [15:0] corner2_x;
    logic [15:0] corner2_y;
    logic [15:0] corner3_x;
    logic [15:0] corner3_y;
    logic [31:0] stamp_sec;
    logic [29:0] stamp_nsec;
  } in_beat_t;

  typedef struct packed {
    logic [15:0]        bot_id;
    logic               id_valid;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] yaw;
    logic [31:0]        out_sec;
    logic [29:0]        out_nsec;
  } out_beat_t;

  // Configuration register indexes
  localparam logic [2:0] REG_OFFSET_X = 3'd0;
  localparam logic [2:0] REG_OFFSET_Y = 3'd1;
  localparam logic [2:0] REG_SCALE    = 3'd2;
  localparam logic [2:0] REG_ROT_COS  = 3'd3;
  localparam logic [2:0] REG_ROT_SIN  = 3'd4;

  typedef struct packed {
    logic signed [20:0] offset_x;
    logic signed [20:0] offset_y;
    logic [23:0]        scale;
    logic signed [15:0] rot_cos;
    logic signed [15:0] rot_sin;
  } cfg_t;

  // Rotated corner coordinate, Q.16
  typedef logic signed [47:0] coord_t;

  // One CORDIC stage: vector, angle (Q.30) and the null-vector flag
  typedef struct packed {
    logic               zero;
    logic signed [49:0] x;
    logic signed [49:0] y;
    logic signed [34:0] z;
  } cstate_t;

  localparam int unsigned ATAN_LEN = 24;
  localparam logic signed [34:0] ANG_PI_Q30 = 35'sd3373259426;
  localparam logic signed [34:0] YAW_MAX    = 35'sd25736;

  function automatic logic signed [34:0] atan_q30(input int unsigned idx);
    logic signed [34:0] a;
    a = '0;
    unique case (idx)
      0:  a = 35'sd843314857;
      1:  a = 35'sd497837829;
      2:  a = 35'sd263043837;
      3:  a = 35'sd133525159;
      4:  a = 35'sd67021687;
      5:  a = 35'sd33543516;
      6:  a = 35'sd16775851;
      7:  a = 35'sd8388437;
      8:  a = 35'sd4194283;
      9:  a = 35'sd2097149;
      10: a = 35'sd1048576;
      11: a = 35'sd524288;
      12: a = 35'sd262144;
      13: a = 35'sd131072;
      14: a = 35'sd65536;
      15: a = 35'sd32768;
      16: a = 35'sd16384;
      17: a = 35'sd8192;
      18: a = 35'sd4096;
      19: a = 35'sd2048;
      20: a = 35'sd1024;
      21: a = 35'sd512;
      22: a = 35'sd256;
      23: a = 35'sd128;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

>>> rtl/core/mcp_lane.sv
// ----------------------------------------------------------------------------
// mcp_lane: one corner transform lane
// Negate x, offset, scale and rotate one corner over three stages.
// ----------------------------------------------------------------------------
module mcp_lane
  import mcp_pkg::*;
(
  input  logic        clk,
  input  logic [2:0]  en,
  input  cfg_t        cfg,
  input  logic [15:0] px,
  input  logic [15:0] py,
  output coord_t      cx,
  output coord_t      cy
);

  logic signed [22:0] dx, dy;
  logic signed [47:0] mx_r, my_r;
  logic signed [43:0] tx, ty;
  logic signed [59:0] xc_r, ys_r, xs_r, yc_r;
  logic signed [60:0] sum_x, sum_y;
  coord_t             cx_r, cy_r;

  assign dx = -$signed({3'b000, px, 4'b0000}) - 23'(cfg.offset_x);
  assign dy = $signed({3'b000, py, 4'b0000}) - 23'(cfg.offset_y);

  // Stage 0: scale
  always_ff @(posedge clk) begin
    if (en[0]) begin
      mx_r <= 48'(dx * $signed({1'b0, cfg.scale}));
      my_r <= 48'(dy * $signed({1'b0, cfg.scale}));
    end
  end

  assign tx = 44'((mx_r + 48'sd8) >>> 4);
  assign ty = 44'((my_r + 48'sd8) >>> 4);

  // Stage 1: rotation products
  always_ff @(posedge clk) begin
    if (en[1]) begin
      xc_r <= 60'(tx * cfg.rot_cos);
      ys_r <= 60'(ty * cfg.rot_sin);
      xs_r <= 60'(tx * cfg.rot_sin);
      yc_r <= 60'(ty * cfg.rot_cos);
    end
  end

  assign sum_x = 61'(xc_r) - 61'(ys_r) + 61'sd8192;
  assign sum_y = 61'(xs_r) + 61'(yc_r) + 61'sd8192;

  // Stage 2: round to Q.16
  always_ff @(posedge clk) begin
    if (en[2]) begin
      cx_r <= 48'(sum_x >>> 14);
      cy_r <= 48'(sum_y >>> 14);
    end
  end

  assign cx = cx_r;
  assign cy = cy_r;

endmodule

>>> rtl/core/mcp_merge.sv
// ----------------------------------------------------------------------------
// mcp_merge: combine the four lanes
// Centroid with saturation, and the heading vector folded into the right half.
// ----------------------------------------------------------------------------
module mcp_merge
  import mcp_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  coord_t             cx [4],
  input  coord_t             cy [4],
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output cstate_t            cs
);

  logic signed [49:0] sx, sy, vx, vy;
  logic signed [47:0] rx, ry;
  logic signed [31:0] pos_x_r, pos_y_r;
  cstate_t            cs_r, cs_nxt;

  assign sx = 50'(cx[0]) + 50'(cx[1]) + 50'(cx[2]) + 50'(cx[3]) + 50'sd2;
  assign sy = 50'(cy[0]) + 50'(cy[1]) + 50'(cy[2]) + 50'(cy[3]) + 50'sd2;
  assign rx = 48'(sx >>> 2);
  assign ry = 48'(sy >>> 2);

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [31:0] r;
    r = 32'(v);
    if (v > 48'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -48'sd2147483648) r = 32'sh80000000;
    return r;
  endfunction

  assign vx = 50'(cx[1]) - 50'(cx[0]);
  assign vy = 50'(cy[1]) - 50'(cy[0]);

  always_comb begin
    cs_nxt.zero = (vx == '0) && (vy == '0);
    cs_nxt.x = vx;
    cs_nxt.y = vy;
    cs_nxt.z = '0;
    // Left half: flip the vector and start from plus or minus pi
    if (vx[49]) begin
      cs_nxt.x = -vx;
      cs_nxt.y = -vy;
      cs_nxt.z = vy[49] ? -ANG_PI_Q30 : ANG_PI_Q30;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pos_x_r <= sat32(rx);
      pos_y_r <= sat32(ry);
      cs_r    <= cs_nxt;
    end
  end

  assign pos_x = pos_x_r;
  assign pos_y = pos_y_r;
  assign cs    = cs_r;

endmodule

>>> rtl/core/mcp_cordic.sv
// ----------------------------------------------------------------------------
// mcp_cordic: pipelined vectoring CORDIC
// One micro-rotation per stage, angle accumulated in Q.30.
// ----------------------------------------------------------------------------
module mcp_cordic
  import mcp_pkg::*;
#(
  parameter int STEPS = 16
) (
  input  logic             clk,
  input  logic [STEPS-1:0] en,
  input  cstate_t          cs_in,
  output cstate_t          cs_out
);

  cstate_t stg_r [STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    cstate_t cur, nxt;
    logic signed [49:0] xs, ys;
    if (i == 0) begin : g_head
      assign cur = cs_in;
    end else begin : g_body
      assign cur = stg_r[i-1];
    end
    assign xs  = cur.x >>> i;
    assign ys  = cur.y >>> i;
    always_comb begin
      nxt = cur;
      if (!cur.y[49]) begin
        nxt.x = cur.x + ys;
        nxt.y = cur.y - xs;
        nxt.z = cur.z + atan_q30(i);
      end else begin
        nxt.x = cur.x - ys;
        nxt.y = cur.y + xs;
        nxt.z = cur.z - atan_q30(i);
      end
    end
    always_ff @(posedge clk) begin
      if (en[i]) begin
        stg_r[i] <= nxt;
      end
    end
  end

  assign cs_out = stg_r[STEPS-1];

endmodule

>>> rtl/core/marker_corners_to_pose_core.sv
// ----------------------------------------------------------------------------
// marker_corners_to_pose_core: marker corners to arena pose
// Four corner lanes, a merge stage, a pipelined CORDIC and an output register.
// ----------------------------------------------------------------------------
//   channel  direction  beat        handshake
//   in_      input      in_beat_t   in_valid / in_stall
//   out_     output     out_beat_t  out_valid / out_stall
//   cfg_     input      24-bit reg  cfg_we, cfg_addr
//
// One beat enters per cycle while in_stall is low. STEPS is CORDIC_STEPS
// capped at 24; the stages are three lane stages, one merge stage, one stage
// per CORDIC step and the output register.
// Each stage advances when it is empty or the one after it moves, so a stall
// on out_ holds only as many stages as are full. Reset clears the valid bits
// and loads the register defaults (scale 1.0, rotation by zero).
// ----------------------------------------------------------------------------
module marker_corners_to_pose_core
  import mcp_pkg::*;
#(
  parameter int ROBOT_COUNT  = 50,
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_beat_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_beat_t   out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [23:0] cfg_wdata
);

  localparam int STEPS = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
  localparam int MERGE = 3;
  localparam int LAST  = STEPS + 4;
  localparam int DEPTH = STEPS + 5;

  typedef struct packed {
    logic [15:0] id;
    logic        idv;
    logic [31:0] sec;
    logic [29:0] nsec;
  } meta_t;

  cfg_t cfg_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.offset_x <= '0;
      cfg_r.offset_y <= '0;
      cfg_r.scale    <= 24'd65536;
      cfg_r.rot_cos  <= 16'sd16384;
      cfg_r.rot_sin  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_OFFSET_X: cfg_r.offset_x <= cfg_wdata[20:0];
        REG_OFFSET_Y: cfg_r.offset_y <= cfg_wdata[20:0];
        REG_SCALE:    cfg_r.scale    <= cfg_wdata;
        REG_ROT_COS:  cfg_r.rot_cos  <= cfg_wdata[15:0];
        REG_ROT_SIN:  cfg_r.rot_sin  <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // Stage valid bits and the ready chain (advance where empty or moving)
  logic [DEPTH-1:0] v_r;
  logic [DEPTH:0]   rdy;

  always_comb begin
    rdy[DEPTH] = !out_stall;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      rdy[i] = !v_r[i] || rdy[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= in_valid;
      for (int i = 1; i < DEPTH; i++) begin
        if (rdy[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  assign in_stall = !rdy[0];

  // Id and timestamp ride alongside the datapath
  meta_t meta_r [LAST];
  logic signed [31:0] posx_r [MERGE+1:LAST-1];
  logic signed [31:0] posy_r [MERGE+1:LAST-1];

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      meta_r[0].id   <= in_data.marker_id;
      meta_r[0].idv  <= in_data.marker_id < 16'(ROBOT_COUNT);
      meta_r[0].sec  <= in_data.stamp_sec;
      meta_r[0].nsec <= in_data.stamp_nsec;
    end
    for (int i = 1; i < LAST; i++) begin
      if (rdy[i]) meta_r[i] <= meta_r[i-1];
    end
  end

  // Corner lanes
  coord_t cx [4];
  coord_t cy [4];
  logic [15:0] px [4];
  logic [15:0] py [4];

  assign px[0] = in_data.corner0_x;  assign py[0] = in_data.corner0_y;
  assign px[1] = in_data.corner1_x;  assign py[1] = in_data.corner1_y;
  assign px[2] = in_data.corner2_x;  assign py[2] = in_data.corner2_y;
  assign px[3] = in_data.corner3_x;  assign py[3] = in_data.corner3_y;

  for (genvar k = 0; k < 4; k++) begin : g_lane
    mcp_lane u_lane (
      .clk (clk),
      .en  (rdy[2:0]),
      .cfg (cfg_r),
      .px  (px[k]),
      .py  (py[k]),
      .cx  (cx[k]),
      .cy  (cy[k])
    );
  end

  // Merge: centroid and heading vector
  logic signed [31:0] pos_x, pos_y;
  cstate_t cs_merge, cs_done;

  mcp_merge u_merge (
    .clk   (clk),
    .en    (rdy[MERGE]),
    .cx    (cx),
    .cy    (cy),
    .pos_x (pos_x),
    .pos_y (pos_y),
    .cs    (cs_merge)
  );

  // Carry the centroid across the CORDIC stages
  always_ff @(posedge clk) begin
    if (rdy[MERGE+1]) begin
      posx_r[MERGE+1] <= pos_x;
      posy_r[MERGE+1] <= pos_y;
    end
    for (int i = MERGE + 2; i < LAST; i++) begin
      if (rdy[i]) begin
        posx_r[i] <= posx_r[i-1];
        posy_r[i] <= posy_r[i-1];
      end
    end
  end

  mcp_cordic #(.STEPS(STEPS)) u_cordic (
    .clk    (clk),
    .en     (rdy[LAST-1:MERGE+1]),
    .cs_in  (cs_merge),
    .cs_out (cs_done)
  );

  // Yaw: round Q.30 to Q.13 and clamp to plus or minus pi
  logic signed [34:0] zr;
  logic signed [15:0] yaw;

  assign zr = (cs_done.z + 35'sd65536) >>> 17;

  always_comb begin
    priority if (cs_done.zero) yaw = '0;
    else if (zr > YAW_MAX)     yaw = 16'(YAW_MAX);
    else if (zr < -YAW_MAX)    yaw = 16'(-YAW_MAX);
    else                       yaw = 16'(zr);
  end

  // Output register
  out_beat_t out_r;

  always_ff @(posedge clk) begin
    if (rdy[LAST]) begin
      out_r.bot_id   <= meta_r[LAST-1].id;
      out_r.id_valid <= meta_r[LAST-1].idv;
      out_r.pos_x    <= posx_r[LAST-1];
      out_r.pos_y    <= posy_r[LAST-1];
      out_r.yaw      <= yaw;
      out_r.out_sec  <= meta_r[LAST-1].sec;
      out_r.out_nsec <= meta_r[LAST-1].nsec;
    end
  end

  assign out_valid = v_r[LAST];
  assign out_data  = out_r;

endmodule
